// File: hw/rtl/hpa_pkg.sv
// Shared types for the handle pool allocator.
// No dependencies; every other file of the block uses it.
package hpa_pkg;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_TRY     = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_NONE_RELEASED = 2'd1,
        ST_NOT_IN_USE    = 2'd2,
        ST_EXHAUSTED     = 2'd3
    } t_status;

    localparam int unsigned HANDLE_W = 8;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_cmd;

endpackage

// File: hw/rtl/hpa_req_if.sv
// Request channel: valid/ready with command and handle.
// Depends on hpa_pkg for the handle width.
interface hpa_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    command;
    logic [hpa_pkg::HANDLE_W-1:0]  handle;

    modport source (output valid, output command, output handle, input ready);
    modport sink   (input valid, input command, input handle, output ready);
endinterface

// File: hw/rtl/hpa_rsp_if.sv
// Response channel: valid/ready with granted handle and status.
// Depends on hpa_pkg for the handle width.
interface hpa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [hpa_pkg::HANDLE_W-1:0]  granted_handle;
    logic [1:0]                    status;

    modport source (output valid, output granted_handle, output status, input ready);
    modport sink   (input valid, input granted_handle, input status, output ready);
endinterface

// File: hw/rtl/hpa_ctrl.sv
// Controller state machine: sequences capture, execute and result transfer.
// Depends on hpa_pkg for the datapath command struct.
module hpa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output hpa_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_ready;
    logic   r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ready     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && r_ready) begin
                        r_state <= S_EXEC;
                        r_ready <= 1'b0;
                    end
                end
                S_EXEC: begin
                    r_state     <= S_OUT;
                    r_out_valid <= 1'b1;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b0;
                        r_ready     <= 1'b1;
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_ready     <= 1'b1;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_in_ready    = r_ready;
    assign o_out_valid   = r_out_valid;
    assign o_cmd.capture = i_in_valid && r_ready;
    assign o_cmd.execute = (r_state == S_EXEC);

`ifndef SYNTHESIS
    a_ready_excl_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_ready && r_out_valid))
        else $error("ready and result valid high together");
    a_capture_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_cmd.execute && !r_ready)
        else $error("capture not followed by execute");
    a_exec_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.execute |=> r_out_valid && !o_cmd.execute)
        else $error("execute not followed by result");
`endif

endmodule

// File: hw/rtl/hpa_datapath.sv
// Datapath: in-use map, release queue memory, pointers, counters, result register.
// Depends on hpa_pkg for command, status and control types.
module hpa_datapath #(
    parameter int unsigned POOL_SIZE = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hpa_pkg::t_dp_cmd              i_cmd,
    input  hpa_pkg::t_cmd                 i_command,
    input  logic [hpa_pkg::HANDLE_W-1:0]  i_handle,
    output logic [hpa_pkg::HANDLE_W-1:0]  o_granted_handle,
    output hpa_pkg::t_status              o_status
);

    localparam int unsigned MAP_DEPTH = (POOL_SIZE < 256) ? POOL_SIZE : 256;
    localparam int unsigned QAW       = $clog2(MAP_DEPTH);
    localparam int unsigned FW        = $clog2(MAP_DEPTH + 1);
    localparam int unsigned CTW       = $clog2(POOL_SIZE + 1);
    localparam int unsigned HW        = hpa_pkg::HANDLE_W;

    logic [HW-1:0]        r_queue [MAP_DEPTH];
    logic [MAP_DEPTH-1:0] r_map, n_map;
    logic [QAW-1:0]       r_head, n_head, r_tail, n_tail;
    logic [FW-1:0]        r_fill, n_fill;
    logic [CTW-1:0]       r_created, n_created;
    hpa_pkg::t_cmd        r_command;
    logic [HW-1:0]        r_handle;
    logic [HW-1:0]        r_rd_data;
    logic [HW-1:0]        r_granted, n_granted;
    hpa_pkg::t_status     r_status, n_status;
    logic                 push;
    logic [CTW+HW-1:0]    created_ext;

    assign created_ext = {{HW{1'b0}}, r_created};

    always_comb begin
        n_map     = r_map;
        n_head    = r_head;
        n_tail    = r_tail;
        n_fill    = r_fill;
        n_created = r_created;
        n_granted = '0;
        n_status  = hpa_pkg::ST_OK;
        push      = 1'b0;
        unique case (r_command)
            hpa_pkg::CMD_ALLOC, hpa_pkg::CMD_TRY: begin
                if (r_fill != '0) begin
                    n_map[r_rd_data[QAW-1:0]] = 1'b1;
                    n_head    = (r_head == QAW'(MAP_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    n_fill    = r_fill - 1'b1;
                    n_granted = r_rd_data;
                end else if (r_command == hpa_pkg::CMD_TRY) begin
                    n_status = hpa_pkg::ST_NONE_RELEASED;
                end else if (r_created < CTW'(POOL_SIZE)) begin
                    if (r_created < CTW'(MAP_DEPTH)) begin
                        n_map[r_created[QAW-1:0]] = 1'b1;
                    end
                    n_created = r_created + 1'b1;
                    n_granted = created_ext[HW-1:0];
                end else begin
                    n_status = hpa_pkg::ST_EXHAUSTED;
                end
            end
            hpa_pkg::CMD_RELEASE: begin
                if (({1'b0, r_handle} < (HW+1)'(MAP_DEPTH)) && r_map[r_handle[QAW-1:0]]
                    && (r_fill < FW'(MAP_DEPTH))) begin
                    n_map[r_handle[QAW-1:0]] = 1'b0;
                    push   = 1'b1;
                    n_tail = (r_tail == QAW'(MAP_DEPTH - 1)) ? '0 : r_tail + 1'b1;
                    n_fill = r_fill + 1'b1;
                end else begin
                    n_status = hpa_pkg::ST_NOT_IN_USE;
                end
            end
            default: begin
                n_status = hpa_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_command <= i_command;
            r_handle  <= i_handle;
            r_rd_data <= r_queue[r_head];
        end
        if (i_cmd.execute) begin
            r_granted <= n_granted;
            r_status  <= n_status;
            if (push) begin
                r_queue[r_tail] <= r_handle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map     <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_fill    <= '0;
            r_created <= '0;
        end else if (i_cmd.execute) begin
            r_map     <= n_map;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_fill    <= n_fill;
            r_created <= n_created;
        end
    end

    assign o_granted_handle = r_granted;
    assign o_status         = r_status;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(MAP_DEPTH))
        else $error("release queue fill out of range");
    a_created_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_created <= CTW'(POOL_SIZE))
        else $error("created count out of range");
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.execute |=> $stable(r_fill) && $stable(r_created) && $stable(r_map))
        else $error("pool state changed outside execute");
`endif

endmodule

// File: hw/rtl/handle_pool_allocator_top.sv
// Handle pool allocator: the request sink and response source around the
// controller and datapath. Depends on hpa_pkg, hpa_req_if, hpa_rsp_if,
// hpa_ctrl and hpa_datapath.
//
// One command is in flight at a time. The release queue memory is read at the
// head pointer at the edge that transfers the command. The next cycle
// executes, updates the in-use map, pointers and counters, and loads the
// result register, from which the result is offered.
// Request ready drops at the transfer and returns the cycle after the result
// is transferred, so a new command is not taken before the last result is
// transferred, and a response stall holds the next command off.
// Every command gives exactly one result. The in-use map clears at reset;
// the release queue needs no clearing pass.
module handle_pool_allocator_top #(
    parameter int unsigned POOL_SIZE = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hpa_req_if.sink    i_req,
    hpa_rsp_if.source  o_rsp
);

    hpa_pkg::t_dp_cmd dp_cmd;

    hpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (dp_cmd)
    );

    hpa_datapath #(
        .POOL_SIZE (POOL_SIZE)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .i_command        (hpa_pkg::t_cmd'(i_req.command)),
        .i_handle         (i_req.handle),
        .o_granted_handle (o_rsp.granted_handle),
        .o_status         (o_rsp.status)
    );

endmodule
